/* sv/qmm_pkg.sv */
package qmm_pkg;

   // field widths
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned THR_W    = 11;
   localparam int unsigned DRIVE_W  = 16;
   localparam int unsigned DUTY_W   = 10;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 11;

   // arm command codes
   localparam logic [CMD_W-1:0] CMD_LOCK      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNLOCK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EMERGENCY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_THROTTLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_THROTTLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_CEILING    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_CEILING  = 3'd4;

   // register reset values
   localparam logic [THR_W-1:0]  START_THROTTLE_RST  = 11'd1100;
   localparam logic [THR_W-1:0]  CUTOFF_THROTTLE_RST = 11'd1020;
   localparam logic [THR_W-1:0]  THROTTLE_OFFSET_RST = 11'd1000;
   localparam logic [DUTY_W-1:0] BASE_CEILING_RST    = 10'd900;
   localparam logic [DUTY_W-1:0] OUTPUT_CEILING_RST  = 10'd1000;

   // arming modes
   typedef enum logic [1:0] {
      MODE_LOCKED  = 2'd0,
      MODE_WAITING = 2'd1,
      MODE_RUNNING = 2'd2,
      MODE_EXITING = 2'd3
   } mode_type;

   // control from the mode machine to the mixer
   typedef struct packed {
      logic     drive_en;
      mode_type mode_after;
   } ctrl_type;

endpackage

/* sv/qmm_mode.sv */
module qmm_mode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [qmm_pkg::CMD_W-1:0]     arm_command,
   input  logic [qmm_pkg::THR_W-1:0]     throttle,
   input  logic [qmm_pkg::THR_W-1:0]     start_throttle,
   output qmm_pkg::ctrl_type             ctrl
);
   import qmm_pkg::*;

   mode_type mode_ff;
   mode_type mode_in;
   mode_type mode_eff;
   logic     thr_above_start;

   // emergency overrides the held mode for this request
   assign mode_eff        = (arm_command == CMD_EMERGENCY) ? MODE_EXITING : mode_ff;
   assign thr_above_start = (throttle > start_throttle);

   // next mode
   always_comb begin
      mode_in = mode_eff;
      unique case (mode_eff)
         MODE_LOCKED: begin
            // locked falls through to the throttle check in the same tick
            if (arm_command != CMD_LOCK) mode_in = MODE_WAITING;
            if (thr_above_start) mode_in = MODE_RUNNING;
         end
         MODE_WAITING: begin
            if (thr_above_start) mode_in = MODE_RUNNING;
         end
         MODE_RUNNING: mode_in = MODE_RUNNING;
         MODE_EXITING: mode_in = MODE_LOCKED;
         default:      mode_in = MODE_LOCKED;
      endcase
   end

   // outputs
   always_comb begin
      ctrl.drive_en   = (mode_eff == MODE_RUNNING);
      ctrl.mode_after = mode_in;
   end

   // mode register, moves once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LOCKED;
      end else if (advance) begin
         mode_ff <= mode_in;
      end
   end

endmodule

/* sv/qmm_mix.sv */
module qmm_mix (
   input  qmm_pkg::ctrl_type                   ctrl,
   input  logic [qmm_pkg::THR_W-1:0]           throttle,
   input  logic signed [qmm_pkg::DRIVE_W-1:0]  height_drive,
   input  logic signed [qmm_pkg::DRIVE_W-1:0]  roll_drive,
   input  logic signed [qmm_pkg::DRIVE_W-1:0]  pitch_drive,
   input  logic signed [qmm_pkg::DRIVE_W-1:0]  yaw_drive,
   input  logic [qmm_pkg::THR_W-1:0]           cutoff_throttle,
   input  logic [qmm_pkg::THR_W-1:0]           throttle_offset,
   input  logic [qmm_pkg::DUTY_W-1:0]          base_ceiling,
   input  logic [qmm_pkg::DUTY_W-1:0]          output_ceiling,
   output logic [qmm_pkg::DUTY_W-1:0]          duty_one,
   output logic [qmm_pkg::DUTY_W-1:0]          duty_two,
   output logic [qmm_pkg::DUTY_W-1:0]          duty_three,
   output logic [qmm_pkg::DUTY_W-1:0]          duty_four
);
   import qmm_pkg::*;

   localparam int unsigned BASE_W = DRIVE_W + 2;   // throttle diff plus height
   localparam int unsigned MIX_W  = DRIVE_W + 3;   // base plus three drives

   logic signed [BASE_W-1:0] base_sum;
   logic [DUTY_W-1:0]        base;
   logic signed [MIX_W-1:0]  base_x, roll_x, pitch_x, yaw_x;
   logic signed [MIX_W-1:0]  mix_one, mix_two, mix_three, mix_four;
   logic                     active;

   function automatic logic [DUTY_W-1:0] clamp_mix(input logic signed [MIX_W-1:0] v,
                                                   input logic [DUTY_W-1:0] hi);
      logic signed [MIX_W-1:0] hi_x;
      hi_x = $signed({{(MIX_W-DUTY_W){1'b0}}, hi});
      if (v < 0)         clamp_mix = '0;
      else if (v > hi_x) clamp_mix = hi;
      else               clamp_mix = v[DUTY_W-1:0];
   endfunction

   // base drive, clamped to 0..base_ceiling
   always_comb begin
      base_sum = $signed({{(BASE_W-THR_W){1'b0}}, throttle})
               - $signed({{(BASE_W-THR_W){1'b0}}, throttle_offset})
               + BASE_W'(height_drive);
      if (base_sum < 0)
         base = '0;
      else if (base_sum > $signed({{(BASE_W-DUTY_W){1'b0}}, base_ceiling}))
         base = base_ceiling;
      else
         base = base_sum[DUTY_W-1:0];
   end

   // X-frame mix
   always_comb begin
      base_x    = $signed({{(MIX_W-DUTY_W){1'b0}}, base});
      roll_x    = MIX_W'(roll_drive);
      pitch_x   = MIX_W'(pitch_drive);
      yaw_x     = MIX_W'(yaw_drive);
      mix_one   = base_x + roll_x - pitch_x - yaw_x;
      mix_two   = base_x + roll_x + pitch_x + yaw_x;
      mix_three = base_x - roll_x + pitch_x - yaw_x;
      mix_four  = base_x - roll_x - pitch_x + yaw_x;
   end

   // zero unless running and at or above cutoff
   assign active = ctrl.drive_en && (throttle >= cutoff_throttle);

   always_comb begin
      if (active) begin
         duty_one   = clamp_mix(mix_one, output_ceiling);
         duty_two   = clamp_mix(mix_two, output_ceiling);
         duty_three = clamp_mix(mix_three, output_ceiling);
         duty_four  = clamp_mix(mix_four, output_ceiling);
      end else begin
         duty_one   = '0;
         duty_two   = '0;
         duty_three = '0;
         duty_four  = '0;
      end
   end

endmodule

/* sv/quad_motor_mixer_with_arming.sv */
// A request passes the input register, then the result register, where rsp_stall can hold it;
// an empty input register still takes a request while a result waits.
// Throughput: one request per cycle unless rsp_stall holds a waiting result.
// The arming mode register advances as each request moves to the result register.
// Reset (synchronous, active high): mode locked, both stages empty, registers at defaults.
module quad_motor_mixer_with_arming (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [qmm_pkg::CMD_W-1:0]           req_arm_command,
   input  logic [qmm_pkg::THR_W-1:0]           req_throttle,
   input  logic signed [qmm_pkg::DRIVE_W-1:0]  req_height_drive,
   input  logic signed [qmm_pkg::DRIVE_W-1:0]  req_roll_drive,
   input  logic signed [qmm_pkg::DRIVE_W-1:0]  req_pitch_drive,
   input  logic signed [qmm_pkg::DRIVE_W-1:0]  req_yaw_drive,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [qmm_pkg::DUTY_W-1:0]          rsp_duty_one,
   output logic [qmm_pkg::DUTY_W-1:0]          rsp_duty_two,
   output logic [qmm_pkg::DUTY_W-1:0]          rsp_duty_three,
   output logic [qmm_pkg::DUTY_W-1:0]          rsp_duty_four,
   output logic [1:0]                          rsp_run_mode,
   input  logic                                csr_write,
   input  logic [qmm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qmm_pkg::CSR_DATA_W-1:0]      csr_data
);
   import qmm_pkg::*;

   // configuration registers
   logic [THR_W-1:0]  start_throttle_ff;
   logic [THR_W-1:0]  cutoff_throttle_ff;
   logic [THR_W-1:0]  throttle_offset_ff;
   logic [DUTY_W-1:0] base_ceiling_ff;
   logic [DUTY_W-1:0] output_ceiling_ff;

   // input stage
   logic                       in_valid_ff;
   logic [CMD_W-1:0]           arm_command_ff;
   logic [THR_W-1:0]           throttle_ff;
   logic signed [DRIVE_W-1:0]  height_drive_ff;
   logic signed [DRIVE_W-1:0]  roll_drive_ff;
   logic signed [DRIVE_W-1:0]  pitch_drive_ff;
   logic signed [DRIVE_W-1:0]  yaw_drive_ff;

   // result stage
   logic              out_valid_ff;
   logic [DUTY_W-1:0] duty_one_ff, duty_two_ff, duty_three_ff, duty_four_ff;
   mode_type          run_mode_ff;

   logic              req_take;
   logic              advance;
   ctrl_type          ctrl;
   logic [DUTY_W-1:0] duty_one_in, duty_two_in, duty_three_in, duty_four_in;

   // handshake: result stage frees when empty or taken
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_throttle_ff  <= START_THROTTLE_RST;
         cutoff_throttle_ff <= CUTOFF_THROTTLE_RST;
         throttle_offset_ff <= THROTTLE_OFFSET_RST;
         base_ceiling_ff    <= BASE_CEILING_RST;
         output_ceiling_ff  <= OUTPUT_CEILING_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_THROTTLE:  start_throttle_ff  <= csr_data[THR_W-1:0];
            CSR_CUTOFF_THROTTLE: cutoff_throttle_ff <= csr_data[THR_W-1:0];
            CSR_THROTTLE_OFFSET: throttle_offset_ff <= csr_data[THR_W-1:0];
            CSR_BASE_CEILING:    base_ceiling_ff    <= csr_data[DUTY_W-1:0];
            CSR_OUTPUT_CEILING:  output_ceiling_ff  <= csr_data[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         arm_command_ff  <= req_arm_command;
         throttle_ff     <= req_throttle;
         height_drive_ff <= req_height_drive;
         roll_drive_ff   <= req_roll_drive;
         pitch_drive_ff  <= req_pitch_drive;
         yaw_drive_ff    <= req_yaw_drive;
      end
   end

   // arming mode machine
   qmm_mode u_mode (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .arm_command    (arm_command_ff),
      .throttle       (throttle_ff),
      .start_throttle (start_throttle_ff),
      .ctrl           (ctrl)
   );

   // mixer datapath
   qmm_mix u_mix (
      .ctrl            (ctrl),
      .throttle        (throttle_ff),
      .height_drive    (height_drive_ff),
      .roll_drive      (roll_drive_ff),
      .pitch_drive     (pitch_drive_ff),
      .yaw_drive       (yaw_drive_ff),
      .cutoff_throttle (cutoff_throttle_ff),
      .throttle_offset (throttle_offset_ff),
      .base_ceiling    (base_ceiling_ff),
      .output_ceiling  (output_ceiling_ff),
      .duty_one        (duty_one_in),
      .duty_two        (duty_two_in),
      .duty_three      (duty_three_in),
      .duty_four       (duty_four_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         duty_one_ff   <= duty_one_in;
         duty_two_ff   <= duty_two_in;
         duty_three_ff <= duty_three_in;
         duty_four_ff  <= duty_four_in;
         run_mode_ff   <= ctrl.mode_after;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_duty_one   = duty_one_ff;
   assign rsp_duty_two   = duty_two_ff;
   assign rsp_duty_three = duty_three_ff;
   assign rsp_duty_four  = duty_four_ff;
   assign rsp_run_mode   = run_mode_ff;

   // exiting mode never survives a request
   a_no_exit_report: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (run_mode_ff != MODE_EXITING))
      else $error("exiting mode reported in result");

   // motors are idle in every mode except running
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (run_mode_ff != MODE_RUNNING)) |->
      (duty_one_ff == '0 && duty_two_ff == '0 && duty_three_ff == '0 && duty_four_ff == '0))
      else $error("nonzero duty outside running mode");

   // a request moved forward shows up as a result next cycle
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced request lost");

   // stall only when the input register holds a blocked request
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("spurious request stall");

endmodule
